### rtl/aiop_pkg.sv
// Shared constants and types for the arcade I/O port block.
package aiop_pkg;

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_FETCH = 2'd2;
    localparam logic [1:0] ACT_IDLE  = 2'd3;

    localparam logic [7:0] PORT_DIP      = 8'h00;
    localparam logic [7:0] PORT_JOYSTICK = 8'h01;
    localparam logic [2:0] PORT_SPRITE_PAGE = 3'b001;
    localparam logic [7:0] PORT_SOUND    = 8'h40;
    localparam logic [7:0] PORT_VIDEO    = 8'h80;

    localparam logic [7:0] DIP_RESET = 8'd101;

    localparam int SPRITE_DEPTH = 32;
    localparam int SPRITE_AW    = 5;

    typedef struct packed {
        logic       dac;
        logic       bank;
        logic [2:0] scroll;
        logic       flip;
        logic       irq;
    } video_t;

    typedef struct packed {
        logic                 wr_en;
        logic                 rd_en;
        logic [SPRITE_AW-1:0] addr;
        logic [7:0]           wdata;
    } mem_req_t;

    typedef struct packed {
        logic       fetch;
        logic [7:0] rd_byte;
        logic [5:0] starts;
    } dec_t;

endpackage

### rtl/aiop_access_if.sv
// Bus access channel interface.
interface aiop_access_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] port;
    logic [7:0] data;
    logic [7:0] joystick;
    logic [2:0] sample_busy;

    modport source (output valid, action, port, data, joystick, sample_busy, input ready);
    modport sink   (input valid, action, port, data, joystick, sample_busy, output ready);
endinterface

### rtl/aiop_result_if.sv
// Access result channel interface.
interface aiop_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [5:0] sample_start;
    logic       dac_level;
    logic       palette_bank;
    logic [2:0] scroll_rows;
    logic       flip_screen;
    logic       irq_enable;

    modport source (output valid, read_data, sample_start, dac_level, palette_bank,
                    scroll_rows, flip_screen, irq_enable, input ready);
    modport sink   (input valid, read_data, sample_start, dac_level, palette_bank,
                    scroll_rows, flip_screen, irq_enable, output ready);
endinterface

### rtl/aiop_sprite_ram.sv
// Sprite RAM: 32 x 8 synchronous memory with per-entry written flags.
module aiop_sprite_ram
(
    input  logic               clk,
    input  logic               rst_n,
    input  aiop_pkg::mem_req_t req,
    output logic [7:0]         rd_data
);

    logic [7:0]                        mem [aiop_pkg::SPRITE_DEPTH];
    logic [aiop_pkg::SPRITE_DEPTH-1:0] written_reg;
    logic [7:0]                        rd_q_reg;
    logic                              rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rd_q_reg <= mem[req.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                written_reg[req.addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_hit_reg <= written_reg[req.addr];
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_q_reg : 8'h00;

endmodule

### rtl/aiop_port_decode.sv
// Port decoder and control registers for sound, video and DIP byte.
module aiop_port_decode
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [1:0]         action,
    input  logic [7:0]         port,
    input  logic [7:0]         data,
    input  logic [7:0]         joystick,
    input  logic [2:0]         sample_busy,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    output aiop_pkg::mem_req_t mem_req,
    output aiop_pkg::dec_t     dec,
    output aiop_pkg::video_t   video
);

    function automatic logic [5:0] sound_starts(input logic [7:0] d, input logic [2:0] busy);
        logic [5:0] s;
        s[0] = d[1];
        s[1] = d[2];
        s[2] = d[3] & ~busy[0];
        s[3] = d[4] & ~busy[1];
        s[4] = d[5];
        s[5] = d[6] & ~busy[2];
        return s;
    endfunction

    logic [7:0]       dip_reg;
    logic [7:0]       last_sound_reg;
    aiop_pkg::video_t video_reg;
    aiop_pkg::video_t video_next;
    logic             is_read;
    logic             is_write;
    logic             is_fetch;
    logic             sprite_hit;
    logic             sound_hit;
    logic             video_hit;

    assign is_read    = (action == aiop_pkg::ACT_READ);
    assign is_write   = (action == aiop_pkg::ACT_WRITE);
    assign is_fetch   = (action == aiop_pkg::ACT_FETCH);
    assign sprite_hit = (port[7:5] == aiop_pkg::PORT_SPRITE_PAGE);
    assign sound_hit  = (port == aiop_pkg::PORT_SOUND);
    assign video_hit  = (port == aiop_pkg::PORT_VIDEO);

    assign mem_req.wr_en = accept && is_write && sprite_hit;
    assign mem_req.rd_en = accept && is_fetch;
    assign mem_req.addr  = port[aiop_pkg::SPRITE_AW-1:0];
    assign mem_req.wdata = data;

    always_comb
    begin
        dec.fetch   = is_fetch;
        dec.rd_byte = 8'h00;
        dec.starts  = 6'h00;
        if (is_read)
        begin
            if (port == aiop_pkg::PORT_DIP)
            begin
                dec.rd_byte = dip_reg;
            end
            else if (port == aiop_pkg::PORT_JOYSTICK)
            begin
                dec.rd_byte = ~joystick;
            end
        end
        if (is_write && sound_hit && (data != last_sound_reg))
        begin
            dec.starts = sound_starts(data, sample_busy);
        end
    end

    always_comb
    begin
        video_next = video_reg;
        if (accept && is_write && sound_hit)
        begin
            video_next.dac = data[7];
        end
        if (accept && is_write && video_hit)
        begin
            video_next.bank   = data[6];
            video_next.scroll = data[5:3];
            video_next.flip   = data[7];
            video_next.irq    = data[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dip_reg        <= aiop_pkg::DIP_RESET;
            last_sound_reg <= 8'h00;
            video_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                dip_reg <= cfg_wdata;
            end
            if (accept && is_write && sound_hit)
            begin
                last_sound_reg <= data;
            end
            video_reg <= video_next;
        end
    end

    assign video = video_reg;

endmodule

### rtl/arcade_io_port_block_core.sv
// Top level of the arcade I/O port block.
//
//  channel   dir   handshake      payload
//  access    in    valid/ready    action, port, data, joystick, sample_busy
//  result    out   valid/ready    read_data, sample_start, dac_level, palette_bank,
//                                 scroll_rows, flip_screen, irq_enable
//  config    in    cfg_we         cfg_wdata (DIP byte)
//
// An access issues the sprite RAM read or write and updates the control registers
// on acceptance; the registered RAM read data then goes to the result register,
// which lets a new access in while a result waits. One access is in flight at a
// time. Reset sets the DIP byte to DIP_RESET and clears the other control
// registers and the sprite RAM written flags at once.
module arcade_io_port_block_core
(
    input  logic                clk,
    input  logic                rst_n,
    aiop_access_if.sink         access,
    aiop_result_if.source       result,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata
);

    logic               accept;
    logic               pend_reg;
    aiop_pkg::dec_t     pend_dec_reg;
    aiop_pkg::mem_req_t mem_req;
    aiop_pkg::dec_t     dec;
    aiop_pkg::video_t   video;
    logic [7:0]         ram_rd_data;
    logic               out_free;
    logic               load_out;
    logic               out_valid_reg;
    logic [7:0]         out_read_data_reg;
    logic [5:0]         out_starts_reg;
    aiop_pkg::video_t   out_video_reg;

    assign access.ready = !pend_reg;
    assign accept       = access.valid && access.ready;
    assign out_free     = !out_valid_reg || result.ready;
    assign load_out     = pend_reg && out_free;

    aiop_port_decode u_decode
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .action      (access.action),
        .port        (access.port),
        .data        (access.data),
        .joystick    (access.joystick),
        .sample_busy (access.sample_busy),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .mem_req     (mem_req),
        .dec         (dec),
        .video       (video)
    );

    aiop_sprite_ram u_ram
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_dec_reg <= dec;
        end
        if (load_out)
        begin
            out_read_data_reg <= pend_dec_reg.fetch ? ram_rd_data : pend_dec_reg.rd_byte;
            out_starts_reg    <= pend_dec_reg.starts;
            out_video_reg     <= video;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pend_reg <= 1'b1;
            end
            else if (load_out)
            begin
                pend_reg <= 1'b0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.read_data    = out_read_data_reg;
    assign result.sample_start = out_starts_reg;
    assign result.dac_level    = out_video_reg.dac;
    assign result.palette_bank = out_video_reg.bank;
    assign result.scroll_rows  = out_video_reg.scroll;
    assign result.flip_screen  = out_video_reg.flip;
    assign result.irq_enable   = out_video_reg.irq;

endmodule

### rtl/aiop_checker.sv
// Port-level checker for the arcade I/O port block, bound to the top level.
module aiop_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] read_data,
    input logic [5:0] sample_start
);

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("access taken while a transfer is still in flight");

    a_result_after_access: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without a pending access");

    a_starts_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (sample_start != 6'h00)) |-> (read_data == 8'h00))
        else $error("sample start reported with nonzero read data");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(read_data) && $stable(sample_start)))
        else $error("stalled result transfer changed");

endmodule

bind arcade_io_port_block_core aiop_checker u_aiop_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (access.valid),
    .in_ready     (access.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .read_data    (result.read_data),
    .sample_start (result.sample_start)
);
